>>> sv/sgjag_pkg.sv
// Shared types and constants of the serpenoid gait joint angle generator.
`timescale 1ns / 1ps

package sgjag_pkg;

  typedef enum logic [1:0] {
    GAIT_SNAKE = 2'd0,
    GAIT_SIDE  = 2'd1,
    GAIT_HELIX = 2'd2,
    GAIT_OFF   = 2'd3
  } gait_e;

  typedef enum logic [1:0] {
    AMP_SEL_SNAKE = 2'd0,
    AMP_SEL_SIDE  = 2'd1,
    AMP_SEL_HELIX = 2'd2
  } amp_e;

  // Phase in 24-bit turns
  localparam logic [23:0] PH_SNAKE_W    = 24'd267018;
  localparam logic [23:0] PH_SNAKE_STEP = 24'd4005265;
  localparam logic [23:0] PH_SIDE_STEP  = 24'd4806318;
  localparam logic [23:0] PH_EIGHTH     = 24'd2097152;
  localparam logic [23:0] PH_HELIX_W    = 24'd80105;
  localparam logic [23:0] PH_HELIX_STEP = 24'd1814854;
  localparam logic [23:0] PH_ROUND      = 24'd2048;

  // Servo counts, 8 fraction bits
  localparam logic [16:0] AMP_SNAKE = 17'd52326;
  localparam logic [16:0] AMP_SIDE  = 17'd78490;
  localparam logic [16:0] AMP_HELIX = 17'd65733;

  localparam logic [9:0] CENTER = 10'd512;

  // Quarter-wave polynomial coefficients
  localparam logic [11:0] SIN_C3 = 12'd2320;
  localparam logic [14:0] SIN_C2 = 15'd21024;
  localparam logic [15:0] SIN_C1 = 16'd51472;
  localparam logic [14:0] SIN_MAX = 15'd32767;

  typedef struct packed {
    logic signed [15:0] time_step;
    logic [5:0]         unit_index;
  } in_t;

  typedef struct packed {
    logic [9:0] yaw_position;
    logic [9:0] pitch_position;
  } out_t;

  // One joint's phase and handling flags
  typedef struct packed {
    logic [11:0] phase;
    logic        neg;
    logic        zero;
    amp_e        amp;
  } lane_t;

  // Sine magnitude with sign and handling flags
  typedef struct packed {
    logic [14:0] mag;
    logic        neg;
    logic        zero;
    amp_e        amp;
  } sine_t;

  function automatic logic [16:0] amp_value(amp_e sel);
    logic [16:0] a;
    case (sel)
      AMP_SEL_SNAKE: a = AMP_SNAKE;
      AMP_SEL_SIDE:  a = AMP_SIDE;
      AMP_SEL_HELIX: a = AMP_HELIX;
      default:       a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> sv/snake_gait_joint_angle_generator.sv
// Top level: serpenoid gait joint angle generator pipeline.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | sgjag_pkg::in_t
//  out     | output    | out_valid_o/out_ready_i | sgjag_pkg::out_t
//  cfg     | input     | cfg_we_i              | cfg_data_i (gait mode)
//
// One transaction per cycle unless the output stalls; stages: input, phase, four sine stages, output.
// The sine polynomial's four chained multiplies set the depth.
// Stages advance on their own, so bubbles close up while the output is stalled.
// Reset clears stage valids and sets the gait mode to off.
`timescale 1ns / 1ps

module snake_gait_joint_angle_generator #(
  parameter int UNIT_COUNT = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sgjag_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sgjag_pkg::out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_data_i
);

  localparam int Stages = 7;

  sgjag_pkg::gait_e mode_q;
  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] load;

  sgjag_pkg::in_t   in_q;
  sgjag_pkg::lane_t yaw_d, pitch_d;
  sgjag_pkg::lane_t yaw_q, pitch_q;
  sgjag_pkg::sine_t yaw_s, pitch_s;
  logic [9:0]       yaw_pos, pitch_pos;
  sgjag_pkg::out_t  out_q;

  always_comb begin
    load[Stages-1] = !valid_q[Stages-1] || out_ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  assign in_ready_o = load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sgjag_pkg::GAIT_OFF;
      valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= sgjag_pkg::gait_e'(cfg_data_i);
      end
      if (load[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  sgjag_phase #(
    .UNIT_COUNT(UNIT_COUNT)
  ) u_phase (
    .in_i   (in_q),
    .mode_i (mode_q),
    .yaw_o  (yaw_d),
    .pitch_o(pitch_d)
  );

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      in_q <= in_data_i;
    end
    if (load[1]) begin
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d;
    end
    if (load[6]) begin
      out_q <= '{yaw_position: yaw_pos, pitch_position: pitch_pos};
    end
  end

  sgjag_sine u_sine_yaw (
    .clk_i (clk_i),
    .en_i  (load[5:2]),
    .lane_i(yaw_q),
    .sine_o(yaw_s)
  );

  sgjag_sine u_sine_pitch (
    .clk_i (clk_i),
    .en_i  (load[5:2]),
    .lane_i(pitch_q),
    .sine_o(pitch_s)
  );

  sgjag_scale u_scale_yaw (
    .sine_i(yaw_s),
    .pos_o (yaw_pos)
  );

  sgjag_scale u_scale_pitch (
    .sine_i(pitch_s),
    .pos_o (pitch_pos)
  );

  assign out_valid_o = valid_q[Stages-1];
  assign out_data_o  = out_q;

endmodule

>>> sv/sgjag_phase.sv
// Gait phase generation for the yaw and pitch joints of one unit.
`timescale 1ns / 1ps

module sgjag_phase #(
  parameter int UNIT_COUNT = 64
) (
  input  sgjag_pkg::in_t   in_i,
  input  sgjag_pkg::gait_e mode_i,
  output sgjag_pkg::lane_t yaw_o,
  output sgjag_pkg::lane_t pitch_o
);

  logic [23:0] t_ext;
  logic [23:0] w;
  logic [23:0] step;
  logic [23:0] t_prod;
  logic [29:0] i_prod;
  logic [23:0] ph;
  logic [23:0] ph_r;
  logic [23:0] ph_lag_r;
  logic [11:0] p;
  logic [11:0] p_lag;
  logic        off;

  always_comb begin
    t_ext = {{8{in_i.time_step[15]}}, in_i.time_step};
    w     = (mode_i == sgjag_pkg::GAIT_HELIX) ? sgjag_pkg::PH_HELIX_W : sgjag_pkg::PH_SNAKE_W;
    case (mode_i)
      sgjag_pkg::GAIT_SIDE:  step = sgjag_pkg::PH_SIDE_STEP;
      sgjag_pkg::GAIT_HELIX: step = sgjag_pkg::PH_HELIX_STEP;
      default:               step = sgjag_pkg::PH_SNAKE_STEP;
    endcase
    t_prod   = t_ext * w;
    i_prod   = in_i.unit_index * step;
    ph       = t_prod + i_prod[23:0];
    ph_r     = ph + sgjag_pkg::PH_ROUND;
    ph_lag_r = ph - sgjag_pkg::PH_EIGHTH + sgjag_pkg::PH_ROUND;
    p        = ph_r[23:12];
    p_lag    = ph_lag_r[23:12];
    off      = (mode_i == sgjag_pkg::GAIT_OFF) ||
               ({3'b000, in_i.unit_index} >= 9'(UNIT_COUNT));

    yaw_o   = '{phase: p, neg: 1'b0, zero: off, amp: sgjag_pkg::AMP_SEL_SNAKE};
    pitch_o = '{phase: p, neg: 1'b0, zero: 1'b1, amp: sgjag_pkg::AMP_SEL_SNAKE};
    case (mode_i)
      sgjag_pkg::GAIT_SIDE: begin
        yaw_o.amp     = sgjag_pkg::AMP_SEL_SIDE;
        pitch_o.amp   = sgjag_pkg::AMP_SEL_SIDE;
        pitch_o.phase = p_lag;
        pitch_o.zero  = off;
      end
      sgjag_pkg::GAIT_HELIX: begin
        yaw_o.amp     = sgjag_pkg::AMP_SEL_HELIX;
        yaw_o.phase   = p + 12'd1024;
        pitch_o.amp   = sgjag_pkg::AMP_SEL_HELIX;
        pitch_o.neg   = 1'b1;
        pitch_o.zero  = off;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/sgjag_sine.sv
// Four-stage quarter-wave polynomial sine of a 12-bit phase.
`timescale 1ns / 1ps

module sgjag_sine (
  input  logic             clk_i,
  input  logic [3:0]       en_i,
  input  sgjag_pkg::lane_t lane_i,
  output sgjag_pkg::sine_t sine_o
);

  typedef struct packed {
    logic        neg;
    logic        zero;
    sgjag_pkg::amp_e amp;
  } flag_t;

  logic [1:0]  q;
  logic [10:0] x;
  logic [15:0] z_d;
  logic [31:0] zz;
  logic [27:0] v1_prod;
  logic [12:0] v1;
  logic [30:0] v2_prod;
  logic [15:0] v2;
  logic [31:0] s_prod;
  logic [16:0] s_raw;

  logic [15:0] a_z_q, a_z2_q;
  flag_t       a_f_q;
  logic [15:0] b_z_q, b_z2_q;
  logic [14:0] b_d1_q;
  flag_t       b_f_q;
  logic [15:0] c_z_q;
  logic [15:0] c_d2_q;
  flag_t       c_f_q;
  logic [14:0] d_s_q;
  flag_t       d_f_q;

  always_comb begin
    q       = lane_i.phase[11:10];
    x       = q[0] ? (11'd1024 - {1'b0, lane_i.phase[9:0]}) : {1'b0, lane_i.phase[9:0]};
    z_d     = {x[10:0], 5'b00000};
    zz      = z_d * z_d;
    v1_prod = sgjag_pkg::SIN_C3 * a_z2_q;
    v1      = v1_prod[27:15];
    v2_prod = b_d1_q * b_z2_q;
    v2      = v2_prod[30:15];
    s_prod  = c_d2_q * c_z_q;
    s_raw   = s_prod[31:15];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a_z_q  <= z_d;
      a_z2_q <= zz[30:15];
      a_f_q  <= '{neg: lane_i.neg ^ q[1], zero: lane_i.zero, amp: lane_i.amp};
    end
    if (en_i[1]) begin
      b_z_q  <= a_z_q;
      b_z2_q <= a_z2_q;
      b_d1_q <= sgjag_pkg::SIN_C2 - 15'(v1);
      b_f_q  <= a_f_q;
    end
    if (en_i[2]) begin
      c_z_q  <= b_z_q;
      c_d2_q <= sgjag_pkg::SIN_C1 - v2;
      c_f_q  <= b_f_q;
    end
    if (en_i[3]) begin
      d_s_q <= (s_raw > 17'(sgjag_pkg::SIN_MAX)) ? sgjag_pkg::SIN_MAX : s_raw[14:0];
      d_f_q <= c_f_q;
    end
  end

  assign sine_o = '{mag: d_s_q, neg: d_f_q.neg, zero: d_f_q.zero, amp: d_f_q.amp};

endmodule

>>> sv/sgjag_scale.sv
// Amplitude scaling of a sine value to a servo goal position.
`timescale 1ns / 1ps

module sgjag_scale (
  input  sgjag_pkg::sine_t sine_i,
  output logic [9:0]       pos_o
);

  logic [31:0] prod;
  logic [32:0] prod_up;
  logic [9:0]  d;

  always_comb begin
    prod    = sgjag_pkg::amp_value(sine_i.amp) * sine_i.mag;
    // Negative side rounds away from centre
    prod_up = {1'b0, prod} + 33'h07FFFFF;
    d       = sine_i.neg ? {1'b0, prod_up[31:23]} : {1'b0, prod[31:23]};
    if (sine_i.zero) begin
      pos_o = sgjag_pkg::CENTER;
    end else if (sine_i.neg) begin
      pos_o = sgjag_pkg::CENTER - d;
    end else begin
      pos_o = sgjag_pkg::CENTER + d;
    end
  end

endmodule

>>> sim/joint_position_checker.sv
// Checker: predicts the servo positions of each input transaction and compares the results.
`timescale 1ns / 1ps
module joint_position_checker #(
  parameter int UNIT_COUNT = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  sgjag_pkg::in_t  in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  sgjag_pkg::out_t out_data_i,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_data_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              checked_o
);

  // Phase in 24-bit turns, amplitudes in servo counts with 8 fraction bits
  localparam logic [31:0] SNAKE_RATE    = 32'd267018;
  localparam logic [31:0] SNAKE_SPACING = 32'd4005265;
  localparam logic [31:0] SIDE_SPACING  = 32'd4806318;
  localparam logic [31:0] EIGHTH_TURN   = 32'd2097152;
  localparam logic [31:0] HELIX_RATE    = 32'd80105;
  localparam logic [31:0] HELIX_SPACING = 32'd1814854;
  localparam int          SNAKE_AMP     = 52326;
  localparam int          SIDE_AMP      = 78490;
  localparam int          HELIX_AMP     = 65733;
  localparam int          CENTRE        = 512;

  sgjag_pkg::gait_e mode;
  sgjag_pkg::out_t  pending_positions[$];
  sgjag_pkg::out_t  want;
  int               fails;
  int               checked;

  function automatic logic [31:0] quarter_wave(logic [31:0] x);
    logic [31:0] z, z2, v, s;
    z  = x << 5;
    z2 = (z * z) >> 15;
    v  = (32'd2320 * z2) >> 15;
    v  = ((32'd21024 - v) * z2) >> 15;
    s  = ((32'd51472 - v) * z) >> 15;
    if (s > 32'd32767) s = 32'd32767;
    return s;
  endfunction

  function automatic int wave_sine(logic [11:0] p);
    logic [31:0] x, s;
    x = p[10] ? 32'd1024 - p[9:0] : {22'd0, p[9:0]};
    s = quarter_wave(x);
    return p[11] ? -int'(s) : int'(s);
  endfunction

  function automatic logic [11:0] turn12(logic [31:0] ph);
    logic [31:0] r;
    r = {8'd0, ph[23:0]} + 32'd2048;
    return r[23:12];
  endfunction

  // Rounding toward minus infinity of amp * s / 2^23
  function automatic logic [9:0] servo_count(int amp, int s);
    longint prod, delta, pos;
    prod = longint'(amp) * longint'(s);
    if (prod >= 0) delta = prod >>> 23;
    else delta = -((-prod + 64'sd8388607) >>> 23);
    pos = CENTRE + delta;
    return pos[9:0];
  endfunction

  function automatic sgjag_pkg::out_t joint_positions(sgjag_pkg::gait_e m,
                                                      sgjag_pkg::in_t item);
    sgjag_pkg::out_t r;
    logic [31:0]     t, u, ph;
    logic [11:0]     p;
    t = {{16{item.time_step[15]}}, item.time_step};
    u = {26'd0, item.unit_index};
    r.yaw_position   = 10'(CENTRE);
    r.pitch_position = 10'(CENTRE);
    if (u >= UNIT_COUNT) return r;
    case (m)
      sgjag_pkg::GAIT_SNAKE: begin
        ph = t * SNAKE_RATE + u * SNAKE_SPACING;
        r.yaw_position = servo_count(SNAKE_AMP, wave_sine(turn12(ph)));
      end
      sgjag_pkg::GAIT_SIDE: begin
        ph = t * SNAKE_RATE + u * SIDE_SPACING;
        r.yaw_position   = servo_count(SIDE_AMP, wave_sine(turn12(ph)));
        r.pitch_position = servo_count(SIDE_AMP, wave_sine(turn12(ph - EIGHTH_TURN)));
      end
      sgjag_pkg::GAIT_HELIX: begin
        ph = t * HELIX_RATE + u * HELIX_SPACING;
        p  = turn12(ph);
        r.yaw_position   = servo_count(HELIX_AMP, wave_sine(p + 12'd1024));
        r.pitch_position = servo_count(HELIX_AMP, -wave_sine(p));
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = sgjag_pkg::GAIT_OFF;
      pending_positions.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_positions.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got yaw %0d pitch %0d",
                   $time, out_data_i.yaw_position, out_data_i.pitch_position);
        end else begin
          want = pending_positions.pop_front();
          checked++;
          if (out_data_i.yaw_position !== want.yaw_position) begin
            fails++;
            $display("%0t: yaw_position mismatch, expected %0d, got %0d",
                     $time, want.yaw_position, out_data_i.yaw_position);
          end
          if (out_data_i.pitch_position !== want.pitch_position) begin
            fails++;
            $display("%0t: pitch_position mismatch, expected %0d, got %0d",
                     $time, want.pitch_position, out_data_i.pitch_position);
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_positions.push_back(joint_positions(mode, in_data_i));
      if (cfg_we_i) mode = sgjag_pkg::gait_e'(cfg_data_i);
    end
    fail_count_o <= fails;
    pending_o    <= pending_positions.size();
    checked_o    <= checked;
  end

endmodule

>>> sim/snake_gait_joint_angle_generator_tb.sv
// Testbench top: stimulus, output back-pressure, watchdog and verdict for the gait generator.
`timescale 1ns / 1ps
module snake_gait_joint_angle_generator_tb;

  localparam int UNITS         = 64;
  localparam int PHASE_ITEMS   = 120;
  localparam int CLOSING_ITEMS = 70;
  localparam int HOLD_CYCLES   = 150;
  localparam int STALL_LIMIT   = 2000;

  logic            clk_i      = 1'b0;
  logic            rst_ni     = 1'b0;
  logic            in_valid_i = 1'b0;
  sgjag_pkg::in_t  in_data_i  = '0;
  logic            in_ready_o;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  sgjag_pkg::out_t out_data_o;
  logic            cfg_we_i   = 1'b0;
  logic [1:0]      cfg_data_i = '0;

  int fail_count;
  int pending;
  int checked;
  int sent         = 0;
  int stall_cycles = 0;
  bit idle_en      = 1'b1;
  bit hold_req     = 1'b0;

  sgjag_pkg::gait_e plan [10] = '{sgjag_pkg::GAIT_SNAKE, sgjag_pkg::GAIT_SIDE,
                                  sgjag_pkg::GAIT_HELIX, sgjag_pkg::GAIT_OFF,
                                  sgjag_pkg::GAIT_HELIX, sgjag_pkg::GAIT_SNAKE,
                                  sgjag_pkg::GAIT_SIDE, sgjag_pkg::GAIT_OFF,
                                  sgjag_pkg::GAIT_SIDE, sgjag_pkg::GAIT_HELIX};

  snake_gait_joint_angle_generator #(
    .UNIT_COUNT (UNITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  joint_position_checker #(
    .UNIT_COUNT (UNITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Output side: ready runs, random idle bursts and one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("snake_gait_joint_angle_generator verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_item(input sgjag_pkg::in_t d);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // Register write once the pipeline has drained
  task automatic set_gait(input sgjag_pkg::gait_e m);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    push_item('{16'sh0000, 6'd0});
    push_item('{16'sh7FFF, 6'd63});
    push_item('{16'sh8000, 6'd0});
    push_item('{16'shFFFF, 6'd63});
    push_item('{16'sh0001, 6'd1});
    push_item('{16'sh5AA5, 6'd42});
  endtask

  function automatic sgjag_pkg::in_t random_item();
    sgjag_pkg::in_t d;
    case ($urandom_range(0, 7))
      0:       d.time_step = 16'sh8000;
      1:       d.time_step = 16'sh7FFF;
      2:       d.time_step = 16'($urandom_range(0, 400) - 200);
      default: d.time_step = 16'($urandom());
    endcase
    d.unit_index = 6'($urandom_range(0, UNITS - 1));
    return d;
  endfunction

  // Mix of scattered items and head-to-tail sweeps along the body at one time step
  task automatic random_phase(input int n);
    sgjag_pkg::in_t d;
    int             k;
    int             last_unit;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 1) == 0) begin
        push_item(random_item());
        k++;
      end else begin
        d         = random_item();
        last_unit = $urandom_range(7, UNITS - 1);
        for (int u = 0; u <= last_unit && k < n; u++) begin
          d.unit_index = 6'(u);
          push_item(d);
          k++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    set_gait(sgjag_pkg::GAIT_SNAKE);
    run_directed();
    set_gait(sgjag_pkg::GAIT_SIDE);
    run_directed();
    set_gait(sgjag_pkg::GAIT_HELIX);
    run_directed();

    for (int p = 0; p < 10; p++) begin
      set_gait(plan[p]);
      if (p == 5) hold_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    idle_en = 1'b0;
    set_gait(sgjag_pkg::GAIT_SNAKE);
    random_phase(CLOSING_ITEMS);
    set_gait(sgjag_pkg::GAIT_HELIX);
    random_phase(CLOSING_ITEMS);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Run covered %0d transactions, %0d results checked, across all four gait modes,",
             sent, checked);
    $display("time and unit extremes, body sweeps, random idling and a long output stall.");
    if (fail_count == 0) begin
      $display("snake_gait_joint_angle_generator verification clean");
    end else begin
      $display("snake_gait_joint_angle_generator verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sgjag_pkg.sv
sv/sgjag_phase.sv
sv/sgjag_sine.sv
sv/sgjag_scale.sv
sv/snake_gait_joint_angle_generator.sv
sim/joint_position_checker.sv
sim/snake_gait_joint_angle_generator_tb.sv
